// ===== rtl/luhn_pkg.sv =====
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared types, constants and digit helpers for the Luhn card number checker.
// ----------------------------------------------------------------------------
package luhn_pkg;

  localparam int IN_W   = 54;                 // binary card number width
  localparam int NDIG   = 17;                 // decimal digits that 54 bits can hold
  localparam int BCD_W  = 4 * NDIG;
  localparam int GRP    = 4;                  // digits summed per partial sum
  localparam int NGRP   = (NDIG + GRP - 1) / GRP;
  localparam int PART_W = 6;                  // up to GRP * 9
  localparam int TOT_W  = 8;                  // up to NDIG * 9
  localparam int CNT_W  = 5;
  localparam int NMUL   = 16;                 // multiples of ten up to NDIG * 9

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_AMEX = 2'd1;
  localparam logic [1:0] KIND_VISA = 2'd2;
  localparam logic [1:0] KIND_MC   = 2'd3;

  localparam logic [CNT_W-1:0] LEN_VISA_SHORT = 5'd13;
  localparam logic [CNT_W-1:0] LEN_AMEX       = 5'd15;
  localparam logic [CNT_W-1:0] LEN_LONG       = 5'd16;

  // Leading digits in BCD.
  localparam logic [7:0] AMEX_LEAD_A = 8'h34;
  localparam logic [7:0] AMEX_LEAD_B = 8'h37;
  localparam logic [3:0] VISA_LEAD   = 4'h4;
  localparam logic [7:0] MC_LEAD_LO  = 8'h51;
  localparam logic [7:0] MC_LEAD_HI  = 8'h55;

  typedef struct packed {
    logic             valid;
    logic [BCD_W-1:0] bcd;
    logic [IN_W-1:0]  bits;
  } stage_t;

  // Luhn contribution of one digit; doubled digits fold back below ten.
  function automatic logic [3:0] luhn_val(input logic [3:0] d, input logic dbl);
    logic [3:0] r;
    if (!dbl) begin
      r = d;
    end else if (d >= 4'd5) begin
      r = 4'({d, 1'b0} - 5'd9);
    end else begin
      r = {d[2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== rtl/luhn_cell.sv =====
// ----------------------------------------------------------------------------
// luhn_cell
// One binary-to-BCD step: add three to every digit above four, shift in a bit.
// ----------------------------------------------------------------------------
module luhn_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  luhn_pkg::stage_t in_stage,
  output luhn_pkg::stage_t out_stage
);

  logic [luhn_pkg::BCD_W-1:0] adj;
  logic                       valid_r;
  logic [luhn_pkg::BCD_W-1:0] bcd_r;
  logic [luhn_pkg::IN_W-1:0]  bits_r;
  logic [luhn_pkg::BCD_W-1:0] bcd_nxt;
  logic [luhn_pkg::IN_W-1:0]  bits_nxt;

  always_comb begin
    for (int i = 0; i < luhn_pkg::NDIG; i++) begin
      adj[4*i +: 4] = (in_stage.bcd[4*i +: 4] >= 4'd5) ?
                      in_stage.bcd[4*i +: 4] + 4'd3 : in_stage.bcd[4*i +: 4];
    end
    bcd_nxt  = {adj[luhn_pkg::BCD_W-2:0], in_stage.bits[luhn_pkg::IN_W-1]};
    bits_nxt = {in_stage.bits[luhn_pkg::IN_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r  <= bcd_nxt;
    bits_r <= bits_nxt;
  end

  assign out_stage = '{valid: valid_r, bcd: bcd_r, bits: bits_r};

endmodule

// ===== rtl/luhn_check.sv =====
// ----------------------------------------------------------------------------
// luhn_check
// Digit count, brand and two-stage Luhn digit sum on the converted number.
// ----------------------------------------------------------------------------
module luhn_check #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  luhn_pkg::stage_t           in_stage,
  output logic                       out_valid,
  output logic                       out_checksum_ok,
  output logic [1:0]                 out_card_kind,
  output logic [luhn_pkg::CNT_W-1:0] out_digit_count
);

  logic [3:0]                  dig [luhn_pkg::NDIG];
  logic [luhn_pkg::CNT_W-1:0]  ndig_c;
  logic                        rng_c;
  logic [1:0]                  kind_c;
  logic [luhn_pkg::PART_W-1:0] part_c [luhn_pkg::NGRP];

  logic                        s1_valid_r;
  logic                        s1_rng_r;
  logic [1:0]                  s1_kind_r;
  logic [luhn_pkg::CNT_W-1:0]  s1_ndig_r;
  logic [luhn_pkg::PART_W-1:0] s1_part_r [luhn_pkg::NGRP];

  logic [luhn_pkg::TOT_W-1:0]  total_c;
  logic                        mult_c;

  logic                        valid_r;
  logic                        ok_r;
  logic [1:0]                  kind_r;
  logic [luhn_pkg::CNT_W-1:0]  ndig_r;

  always_comb begin
    for (int i = 0; i < luhn_pkg::NDIG; i++) begin
      dig[i] = in_stage.bcd[4*i +: 4];
    end
    ndig_c = '0;
    for (int i = 0; i < luhn_pkg::NDIG; i++) begin
      if (dig[i] != 4'd0) begin
        ndig_c = luhn_pkg::CNT_W'(i + 1);
      end
    end
    rng_c = (ndig_c != '0) && (ndig_c <= luhn_pkg::CNT_W'(MAX_DIGITS));

    kind_c = luhn_pkg::KIND_NONE;
    if (ndig_c == luhn_pkg::LEN_AMEX &&
        ({dig[14], dig[13]} == luhn_pkg::AMEX_LEAD_A ||
         {dig[14], dig[13]} == luhn_pkg::AMEX_LEAD_B)) begin
      kind_c = luhn_pkg::KIND_AMEX;
    end else if (ndig_c == luhn_pkg::LEN_VISA_SHORT && dig[12] == luhn_pkg::VISA_LEAD) begin
      kind_c = luhn_pkg::KIND_VISA;
    end else if (ndig_c == luhn_pkg::LEN_LONG && dig[15] == luhn_pkg::VISA_LEAD) begin
      kind_c = luhn_pkg::KIND_VISA;
    end else if (ndig_c == luhn_pkg::LEN_LONG &&
                 {dig[15], dig[14]} >= luhn_pkg::MC_LEAD_LO &&
                 {dig[15], dig[14]} <= luhn_pkg::MC_LEAD_HI) begin
      kind_c = luhn_pkg::KIND_MC;
    end
    if (!rng_c) begin
      kind_c = luhn_pkg::KIND_NONE;
    end

    for (int g = 0; g < luhn_pkg::NGRP; g++) begin
      part_c[g] = '0;
      for (int j = 0; j < luhn_pkg::GRP; j++) begin
        if (g * luhn_pkg::GRP + j < luhn_pkg::NDIG) begin
          part_c[g] = part_c[g] + luhn_pkg::PART_W'(luhn_pkg::luhn_val(
                        dig[g * luhn_pkg::GRP + j], ((g * luhn_pkg::GRP + j) % 2) == 1));
        end
      end
    end
  end

  always_comb begin
    total_c = '0;
    for (int g = 0; g < luhn_pkg::NGRP; g++) begin
      total_c = total_c + luhn_pkg::TOT_W'(s1_part_r[g]);
    end
    mult_c = 1'b0;
    for (int k = 0; k < luhn_pkg::NMUL; k++) begin
      if (total_c == luhn_pkg::TOT_W'(10 * k)) begin
        mult_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      s1_valid_r <= in_stage.valid;
      valid_r    <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_rng_r  <= rng_c;
    s1_kind_r <= kind_c;
    s1_ndig_r <= ndig_c;
    s1_part_r <= part_c;
    ok_r      <= s1_rng_r && mult_c;
    kind_r    <= s1_kind_r;
    ndig_r    <= s1_ndig_r;
  end

  assign out_valid       = valid_r;
  assign out_checksum_ok = ok_r;
  assign out_card_kind   = kind_r;
  assign out_digit_count = ndig_r;

endmodule

// ===== rtl/luhn_card_number_check_unit.sv =====
// ----------------------------------------------------------------------------
// luhn_card_number_check_unit
// Luhn mod-10 card number check with digit count and brand classification.
// ----------------------------------------------------------------------------
// The unit takes one binary card number in every cycle (busy stays low) and
// returns its result as a one-cycle out_valid strobe, in the order of the
// start beats. Each number passes through the conversion to decimal, a row of
// 54 cells, one per input bit, each shifting one bit into a 17-digit BCD word,
// and then through two stages that count digits, classify the brand and add
// the Luhn digit sum. The receiver cannot stall the unit; every result
// must be taken in the cycle it appears.
// ----------------------------------------------------------------------------
module luhn_card_number_check_unit #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [luhn_pkg::IN_W-1:0]  in_card_number,
  output logic                       out_valid,
  output logic                       out_checksum_ok,
  output logic [1:0]                 out_card_kind,
  output logic [luhn_pkg::CNT_W-1:0] out_digit_count
);

  localparam int LAT = luhn_pkg::IN_W + 2;

  luhn_pkg::stage_t chain [luhn_pkg::IN_W + 1];

  assign busy     = 1'b0;
  assign chain[0] = '{valid: start && !busy, bcd: '0, bits: in_card_number};

  for (genvar k = 0; k < luhn_pkg::IN_W; k++) begin : g_cell
    luhn_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_stage (chain[k]),
      .out_stage(chain[k+1])
    );
  end

  luhn_check #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stage       (chain[luhn_pkg::IN_W]),
    .out_valid      (out_valid),
    .out_checksum_ok(out_checksum_ok),
    .out_card_kind  (out_card_kind),
    .out_digit_count(out_digit_count)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("result beat missing after start");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result beat without matching start");

  a_kind_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_card_kind != luhn_pkg::KIND_NONE |->
      (out_digit_count == luhn_pkg::LEN_VISA_SHORT ||
       out_digit_count == luhn_pkg::LEN_AMEX ||
       out_digit_count == luhn_pkg::LEN_LONG))
    else $error("brand reported for impossible digit count");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_ok |-> out_digit_count != '0)
    else $error("checksum passed for zero");

endmodule
